FILE: rtl/core/mdr_pkg.sv
// Shared types, constants and sine table function for the mecanum odometry block.
package mdr_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_CAL    = 3'd1;
  localparam logic [2:0] CMD_START  = 3'd2;
  localparam logic [2:0] CMD_GOAL   = 3'd3;
  localparam logic [2:0] CMD_CENTRE = 3'd4;

  localparam logic [1:0] REG_SIDE    = 2'd0;
  localparam logic [1:0] REG_START_X = 2'd1;
  localparam logic [1:0] REG_START_Y = 2'd2;
  localparam logic [1:0] REG_START_H = 2'd3;

  localparam logic [1:0] SIDE_RED  = 2'd1;
  localparam logic [1:0] SIDE_BLUE = 2'd2;

  localparam logic signed [16:0] RED_GOAL_X  = 17'sd1440;
  localparam logic signed [16:0] BLUE_GOAL_X = 17'sd7200;
  localparam logic signed [16:0] GOAL_Y      = 17'sd7200;
  localparam logic signed [16:0] CENTRE_XY   = 17'sd4320;
  localparam logic signed [16:0] POS_MIN     = -17'sd65536;
  localparam logic signed [16:0] POS_MAX     = 17'sd65535;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SERIES_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  localparam logic [20:0] RECIP_225  = 21'd1193047;
  localparam logic [20:0] RECIP_1875 = 21'd1145326;

  typedef struct packed {
    logic [1:0]  side;
    logic [13:0] start_x;
    logic [13:0] start_y;
    logic [11:0] start_h;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic idx;
    logic trig;
    logic mul;
    logic div1;
    logic div2;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic go;
  } dp_stat_t;

  function automatic logic [15:0] sin_entry(input int k, input int qbits);
    longint unsigned x, x2, term, sum, r;
    x = (HALF_PI_Q30 * longint'(k)) >> qbits;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[n];
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    r = (sum + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

endpackage

FILE: rtl/core/mdr_regs.sv
// Configuration register file behind the APB-style port.
module mdr_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mdr_pkg::cfg_t      cfg
);
  import mdr_pkg::*;

  cfg_t cfg_r;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_SIDE:    cfg_r.side    <= pwdata[1:0];
        REG_START_X: cfg_r.start_x <= pwdata[13:0];
        REG_START_Y: cfg_r.start_y <= pwdata[13:0];
        REG_START_H: cfg_r.start_h <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SIDE:    prdata = {30'd0, cfg_r.side};
      REG_START_X: prdata = {18'd0, cfg_r.start_x};
      REG_START_Y: prdata = {18'd0, cfg_r.start_y};
      REG_START_H: prdata = {20'd0, cfg_r.start_h};
      default:     prdata = '0;
    endcase
  end
endmodule

FILE: rtl/core/mdr_ctrl.sv
// Sequencer that steps one item through the odometry datapath.
module mdr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_busy,
  input  mdr_pkg::dp_stat_t  stat,
  output mdr_pkg::dp_cmd_t   cmd
);
  import mdr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_TRIG = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV1 = 3'd5;
  localparam logic [2:0] S_DIV2 = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        if (stat.go) begin
          cmd.idx = 1'b1;
          state_nxt = S_TRIG;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_TRIG: begin
        cmd.trig = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        cmd.div1 = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2 = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

FILE: rtl/core/mdr_datapath.sv
// Odometry datapath: classification, angle index, sine ROM, travel scaling and state update.
module mdr_datapath #(
  parameter int SINE_TABLE_BITS = mdr_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mdr_pkg::dp_cmd_t    cmd,
  output mdr_pkg::dp_stat_t   stat,
  input  mdr_pkg::cfg_t       cfg,
  input  logic [2:0]          in_command,
  input  logic signed [8:0]   in_rpm_left_back,
  input  logic signed [8:0]   in_rpm_right_back,
  input  logic signed [8:0]   in_rpm_left_front,
  input  logic signed [8:0]   in_rpm_right_front,
  input  logic signed [12:0]  in_gyro_reading,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [16:0]  out_pos_x,
  output logic signed [16:0]  out_pos_y,
  output logic signed [13:0]  out_heading_out,
  output logic                out_moving,
  output logic                out_busy
);
  import mdr_pkg::*;

  localparam int B      = SINE_TABLE_BITS;
  localparam int QSTEPS = 1 << (B - 2);
  localparam int WV     = 12 + B + 1;
  localparam int WP     = WV - 4 + 21;

  logic [15:0] rom [QSTEPS+1];
  for (genvar k = 0; k <= QSTEPS; k++) begin : g_rom
    assign rom[k] = sin_entry(k, B - 2);
  end

  logic signed [16:0] pos_x_r, pos_y_r;
  logic signed [13:0] heading_r, offset_r;

  logic [2:0]         cmd_r;
  logic signed [8:0]  lb_r, rb_r, lf_r, rf_r;
  logic signed [12:0] gyro_r;

  logic               go_r, moving_r;
  logic signed [11:0] sum_r;
  logic [11:0]        ang_r;
  logic [B-1:0]       idx_r;
  logic [15:0]        rom_s_r, rom_c_r;
  logic               neg_s_r, neg_c_r;
  logic signed [27:0] px_r, py_r;
  logic [20:0]        tx_r, ty_r;
  logic               sx_r, sy_r;
  logic [10:0]        qx_r, qy_r;

  logic out_valid_r, out_moving_r;
  logic signed [16:0] out_x_r, out_y_r;
  logic signed [13:0] out_h_r;

  assign stat.go = go_r;
  assign out_valid = out_valid_r;
  assign out_pos_x = out_x_r;
  assign out_pos_y = out_y_r;
  assign out_heading_out = out_h_r;
  assign out_moving = out_moving_r;
  assign out_busy = out_valid_r && out_stall;

  // classification
  logic signed [9:0] lb10, rb10, lf10, rf10;
  logic signed [9:0] alb, arb, alf, arf;
  logic mv, lin, strl, strr;
  logic signed [11:0] ssum, asum;
  logic signed [14:0] ang_raw, ang_mod;

  always_comb begin
    lb10 = {lb_r[8], lb_r};
    rb10 = {rb_r[8], rb_r};
    lf10 = {lf_r[8], lf_r};
    rf10 = {rf_r[8], rf_r};
    alb = lb10[9] ? -lb10 : lb10;
    arb = rb10[9] ? -rb10 : rb10;
    alf = lf10[9] ? -lf10 : lf10;
    arf = rf10[9] ? -rf10 : rf10;
    mv = (cmd_r == CMD_TICK) &&
         (alb >= 10'sd5 || arb >= 10'sd5 || alf >= 10'sd5 || arf >= 10'sd5);
    lin = (lb_r > 0 && rb_r > 0 && lf_r > 0 && rf_r > 0) ||
          (lb_r < 0 && rb_r < 0 && lf_r < 0 && rf_r < 0) ||
          (lb_r < 0 && rb_r > 0 && lf_r < 0 && rf_r > 0) ||
          (lb_r > 0 && rb_r < 0 && lf_r > 0 && rf_r < 0);
    strl = lb_r < 0 && rb_r > 0 && lf_r > 0 && rf_r < 0;
    strr = lb_r > 0 && rb_r < 0 && lf_r < 0 && rf_r > 0;
    ssum = 12'(lb10) + 12'(rb10) + 12'(lf10) + 12'(rf10);
    asum = 12'(alb) + 12'(arb) + 12'(alf) + 12'(arf);
    priority if (strl) ang_raw = 15'(heading_r) + 15'sd900;
    else if (strr) ang_raw = 15'(heading_r) - 15'sd900;
    else ang_raw = 15'(heading_r);
    priority if (ang_raw < -15'sd3600) ang_mod = ang_raw + 15'sd7200;
    else if (ang_raw < 15'sd0) ang_mod = ang_raw + 15'sd3600;
    else if (ang_raw >= 15'sd7200) ang_mod = ang_raw - 15'sd7200;
    else if (ang_raw >= 15'sd3600) ang_mod = ang_raw - 15'sd3600;
    else ang_mod = ang_raw;
  end

  // angle to table index
  logic [WV-1:0]  v;
  logic [WV-5:0]  u;
  logic [WP-1:0]  pr;
  always_comb begin
    v = (WV'(ang_r) << B) + WV'(1800);
    u = v[WV-1:4];
    pr = WP'(u) * WP'(RECIP_225);
  end

  // quadrant folding
  logic [B-1:0] idx_c;
  logic [B-2:0] ri_s, ri_c;
  always_comb begin
    idx_c = idx_r + B'(QSTEPS);
    ri_s = idx_r[B-2] ? (B-1)'(QSTEPS) - (B-1)'(idx_r[B-3:0]) : (B-1)'(idx_r[B-3:0]);
    ri_c = idx_c[B-2] ? (B-1)'(QSTEPS) - (B-1)'(idx_c[B-3:0]) : (B-1)'(idx_c[B-3:0]);
  end

  // travel scaling
  logic signed [15:0] trig_s, trig_c;
  logic [26:0] mag_x, mag_y;
  logic [36:0] mx, my;
  logic [41:0] qpx, qpy;
  always_comb begin
    trig_s = neg_s_r ? -$signed(rom_s_r) : $signed(rom_s_r);
    trig_c = neg_c_r ? -$signed(rom_c_r) : $signed(rom_c_r);
    mag_x = px_r[27] ? 27'(-px_r) : 27'(px_r);
    mag_y = py_r[27] ? 27'(-py_r) : 27'(py_r);
    mx = 37'(mag_x) * 37'(628) + 37'(30720000);
    my = 37'(mag_y) * 37'(628) + 37'(30720000);
    qpx = 42'(tx_r) * 42'(RECIP_1875);
    qpy = 42'(ty_r) * 42'(RECIP_1875);
  end

  // state update
  logic signed [17:0] dx, dy, nx_w, ny_w;
  logic signed [16:0] nx, ny;
  logic signed [13:0] nh, noff;
  logic signed [15:0] hw, ow;
  always_comb begin
    dx = sx_r ? -18'(qx_r) : 18'(qx_r);
    dy = sy_r ? -18'(qy_r) : 18'(qy_r);
    nx_w = 18'(pos_x_r) + dx;
    ny_w = 18'(pos_y_r) + dy;
    nx = pos_x_r;
    ny = pos_y_r;
    nh = heading_r;
    noff = offset_r;
    hw = 16'(gyro_r) - 16'(offset_r);
    if (hw < 0) hw = hw + 16'sd3600;
    ow = 16'(gyro_r) - $signed({4'd0, cfg.start_h});
    if (gyro_r < 0) ow = ow + 16'sd3600;
    unique case (cmd_r)
      CMD_TICK: begin
        if (go_r) begin
          priority if (nx_w < 18'(POS_MIN)) nx = POS_MIN;
          else if (nx_w > 18'(POS_MAX)) nx = POS_MAX;
          else nx = nx_w[16:0];
          priority if (ny_w < 18'(POS_MIN)) ny = POS_MIN;
          else if (ny_w > 18'(POS_MAX)) ny = POS_MAX;
          else ny = ny_w[16:0];
        end
        priority if (hw < -16'sd3600) nh = -14'sd3600;
        else if (hw > 16'sd7199) nh = 14'sd7199;
        else nh = hw[13:0];
      end
      CMD_CAL: noff = ow[13:0];
      CMD_START: begin
        nx = $signed({3'd0, cfg.start_x});
        ny = $signed({3'd0, cfg.start_y});
      end
      CMD_GOAL: begin
        if (cfg.side == SIDE_RED) begin
          nx = RED_GOAL_X;
          ny = GOAL_Y;
        end else if (cfg.side == SIDE_BLUE) begin
          nx = BLUE_GOAL_X;
          ny = GOAL_Y;
        end
      end
      CMD_CENTRE: begin
        nx = CENTRE_XY;
        ny = CENTRE_XY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      lb_r   <= in_rpm_left_back;
      rb_r   <= in_rpm_right_back;
      lf_r   <= in_rpm_left_front;
      rf_r   <= in_rpm_right_front;
      gyro_r <= in_gyro_reading;
    end
    if (cmd.eval) begin
      sum_r <= lin ? ssum : asum;
      ang_r <= ang_mod[11:0];
    end
    if (cmd.idx) idx_r <= pr[28 +: B];
    if (cmd.trig) begin
      rom_s_r <= rom[ri_s];
      rom_c_r <= rom[ri_c];
      neg_s_r <= idx_r[B-1];
      neg_c_r <= idx_c[B-1];
    end
    if (cmd.mul) begin
      px_r <= 28'(sum_r) * 28'(trig_c);
      py_r <= 28'(sum_r) * 28'(trig_s);
    end
    if (cmd.div1) begin
      tx_r <= mx[35:15];
      ty_r <= my[35:15];
      sx_r <= px_r[27];
      sy_r <= py_r[27];
    end
    if (cmd.div2) begin
      qx_r <= qpx[41:31];
      qy_r <= qpy[41:31];
    end
    if (cmd.fin) begin
      out_x_r      <= nx;
      out_y_r      <= ny;
      out_h_r      <= nh;
      out_moving_r <= moving_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      offset_r    <= '0;
      go_r        <= 1'b0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.eval) begin
        go_r     <= mv && (lin || strl || strr);
        moving_r <= mv;
      end
      if (cmd.fin) begin
        pos_x_r   <= nx;
        pos_y_r   <= ny;
        heading_r <= nh;
        offset_r  <= noff;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end
endmodule

FILE: rtl/core/mecanum_dead_reckoning_odometry_top.sv
// Top level of the mecanum dead-reckoning odometry block.
//
//  channel  handshake            payload
//  in       in_valid / in_stall  command, four wheel rpms, gyro reading
//  out      out_valid / out_stall pos_x, pos_y, heading_out, moving
//  cfg      psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// A moving tick takes one sequencer step each for classify, angle index, sine ROM
// read, multiply, two scaling steps and update. Other items skip the steps between
// index and update. The next item is accepted in the cycle after the update.
// Reset (rst_n low, synchronous) clears position, heading, offset, config and the
// output valid flag. A waiting result holds the last step until out_stall drops.
module mecanum_dead_reckoning_odometry_top #(
  parameter int SINE_TABLE_BITS = mdr_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic signed [8:0]  in_rpm_left_back,
  input  logic signed [8:0]  in_rpm_right_back,
  input  logic signed [8:0]  in_rpm_left_front,
  input  logic signed [8:0]  in_rpm_right_front,
  input  logic signed [12:0] in_gyro_reading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [13:0] out_heading_out,
  output logic               out_moving,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mdr_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_busy;

  mdr_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  mdr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_busy), .stat(stat), .cmd(cmd)
  );

  mdr_datapath #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .cfg(cfg),
    .in_command(in_command),
    .in_rpm_left_back(in_rpm_left_back),
    .in_rpm_right_back(in_rpm_right_back),
    .in_rpm_left_front(in_rpm_left_front),
    .in_rpm_right_front(in_rpm_right_front),
    .in_gyro_reading(in_gyro_reading),
    .out_stall(out_stall), .out_valid(out_valid),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_heading_out(out_heading_out), .out_moving(out_moving),
    .out_busy(out_busy)
  );
endmodule
